// ===== sv/lmsc_pkg.sv =====
// ----------------------------------------------------------------------------
// Lane margin sweep controller package
// Shared types and constants for the lane margin sweep controller.
// ----------------------------------------------------------------------------
package lmsc_pkg;

  localparam int SLOT_COUNT_DEF = 32;
  localparam int CNT_W          = 6;   // width of lane_count and of the lane total
  localparam int STEP_W         = 7;
  localparam int VERD_W         = 2;
  localparam int KIND_W         = 2;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RECEIVER    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ERR_CEILING = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_STEPS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LANE_COUNT  = 3'd4;

  // Sweep directions.
  localparam logic [1:0] DIR_TIMING_LEFT  = 2'd0;
  localparam logic [1:0] DIR_TIMING_RIGHT = 2'd1;
  localparam logic [1:0] DIR_VOLTAGE_UP   = 2'd2;
  localparam logic [1:0] DIR_VOLTAGE_DOWN = 2'd3;

  // Margin command types.
  localparam logic [2:0] MTYPE_TIMING  = 3'd3;
  localparam logic [2:0] MTYPE_VOLTAGE = 3'd4;

  // Margin status code that means the step was accepted.
  localparam logic [1:0] MSTS_MARGINING = 2'd2;

  // Lane verdicts.
  localparam logic [VERD_W-1:0] VERDICT_THRESHOLD = 2'd0;
  localparam logic [VERD_W-1:0] VERDICT_NAK       = 2'd1;
  localparam logic [VERD_W-1:0] VERDICT_LIMIT     = 2'd2;

  // Result word kinds.
  localparam logic [KIND_W-1:0] KIND_STEP_CMD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FAILED   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FINAL    = 2'd2;

  // Input operations.
  localparam logic OP_START    = 1'b0;
  localparam logic OP_READBACK = 1'b1;

  typedef struct packed {
    logic [STEP_W-1:0] steps;
    logic [VERD_W-1:0] verdict;
  } rec_t;

  typedef struct packed {
    logic              pass;
    logic [VERD_W-1:0] verdict;
  } chk_t;

endpackage

// ===== sv/lmsc_rec_mem.sv =====
// ----------------------------------------------------------------------------
// Lane record memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lmsc_rec_mem #(
  parameter int DEPTH  = lmsc_pkg::SLOT_COUNT_DEF,
  parameter int ADDR_W = 5
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  lmsc_pkg::rec_t      wr_data,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output lmsc_pkg::rec_t      rd_data
);

  lmsc_pkg::rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/lmsc_check.sv =====
// ----------------------------------------------------------------------------
// Lane status readback check
// Decides whether a readback passes and which verdict a failure carries.
// ----------------------------------------------------------------------------
module lmsc_check (
  input  logic [15:0]    status_word,
  input  logic           idle_ack,
  input  logic [2:0]     receiver_number,
  input  logic [5:0]     err_ceiling,
  input  logic [1:0]     direction,
  output lmsc_pkg::chk_t chk
);

  logic [2:0] exp_type;
  logic [1:0] sts;

  always_comb begin
    exp_type = (direction == lmsc_pkg::DIR_TIMING_LEFT ||
                direction == lmsc_pkg::DIR_TIMING_RIGHT) ?
               lmsc_pkg::MTYPE_TIMING : lmsc_pkg::MTYPE_VOLTAGE;
    sts = status_word[15:14];
    chk.pass = (status_word[5:3] == exp_type) &&
               (status_word[2:0] == receiver_number) &&
               (sts == lmsc_pkg::MSTS_MARGINING) &&
               (status_word[13:8] <= err_ceiling) &&
               idle_ack;
    // Margin status 1 or 3 is a refusal; anything else is a limit failure.
    chk.verdict = sts[0] ? lmsc_pkg::VERDICT_NAK : lmsc_pkg::VERDICT_LIMIT;
  end

endmodule

// ===== sv/lane_margin_sweep_controller_core.sv =====
// ----------------------------------------------------------------------------
// Lane margin sweep controller core
// Controller side of a receiver lane-margining sweep in one direction.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake              Payload
//   -------   --------------------   -------------------------------------------
//   cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//   in        in_valid  / in_ready   op, lane_slot, status_word, idle_ack
//   out       out_valid / out_ready  kind, command_word, slot, lane_steps,
//                                    lane_verdict, last
//
// A readback word goes through the check state, after the failure state when
// it fails the lane, and on through the advance and command states to a step
// command when it completes the round; an ignored one leaves the sequencer
// idle. A start word goes through the advance state to its step command or
// to the close. Closing a sweep takes the step decision, a read of the record
// memory, then one final record per slot, one per cycle while out_ready holds,
// through the single read port. Reset is synchronous and needs no clearing
// pass: record memory data is used only for lanes whose failed bit is set, and
// a lane that never failed reads as the step total latched at start with
// verdict threshold reached. The output register stalls the sequencer while
// out_ready is low; input is taken only when idle; configuration is always ready.
// ----------------------------------------------------------------------------
module lane_margin_sweep_controller_core #(
  parameter int SLOT_COUNT = lmsc_pkg::SLOT_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lmsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lmsc_pkg::CFG_DATA_W-1:0]   cfg_data,
  // Input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              op,
  input  logic [4:0]                        lane_slot,
  input  logic [15:0]                       status_word,
  input  logic                              idle_ack,
  // Output channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lmsc_pkg::KIND_W-1:0]       kind,
  output logic [15:0]                       command_word,
  output logic [4:0]                        slot,
  output logic [lmsc_pkg::STEP_W-1:0]       lane_steps,
  output logic [lmsc_pkg::VERD_W-1:0]       lane_verdict,
  output logic                              last
);

  localparam int LANE_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W  = lmsc_pkg::CNT_W;
  localparam int STEP_W = lmsc_pkg::STEP_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FAIL,
    S_CHK,
    S_ADV,
    S_CMD,
    S_FIN_RD,
    S_FIN_EMIT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [2:0]        receiver_number;
  logic [5:0]        err_ceiling;
  logic [1:0]        direction;
  logic [STEP_W-1:0] total_steps;
  logic [CNT_W-1:0]  lane_count;

  // Sweep state.
  logic [STEP_W-1:0]     step_num;
  logic [STEP_W-1:0]     start_steps;
  logic                  sweep_active;
  logic [SLOT_COUNT-1:0] failed_mask;
  logic [SLOT_COUNT-1:0] reported_mask;
  logic [LANE_W-1:0]     fin_idx;
  logic [4:0]            fail_slot;
  lmsc_pkg::rec_t        fail_rec;

  // Combinational helpers.
  logic [CNT_W-1:0]      lanes_used;
  logic [SLOT_COUNT-1:0] lane_mask;
  logic [SLOT_COUNT-1:0] alive;
  logic                  in_fire;
  logic                  out_free;
  logic                  out_load;
  logic                  rb_ok;
  logic [LANE_W-1:0]     slot_idx;
  logic                  fin_last;
  logic [7:0]            cmd_payload;
  logic [2:0]            cmd_type;
  logic [15:0]           cmd_word;
  lmsc_pkg::chk_t        chk;
  lmsc_pkg::rec_t        wr_rec;
  lmsc_pkg::rec_t        rd_rec;
  lmsc_pkg::rec_t        fin_rec;
  logic                  mem_wr;
  logic                  mem_rd;
  logic [LANE_W-1:0]     mem_rd_addr;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // The output register takes a new word in the emitting states once free.
  assign out_load = out_free &&
                    ((state == S_FAIL) || (state == S_CMD) || (state == S_FIN_EMIT));

  // Lane counts above the supported number of slots are clamped.
  assign lanes_used = (lane_count > CNT_W'(SLOT_COUNT)) ? CNT_W'(SLOT_COUNT) : lane_count;

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      lane_mask[i] = (CNT_W'(i) < lanes_used);
    end
  end

  assign alive    = lane_mask & ~failed_mask;
  assign slot_idx = lane_slot[LANE_W-1:0];

  // A readback counts only during a sweep, for a slot in range that has
  // neither failed nor reported in this step.
  assign rb_ok = sweep_active && ({1'b0, lane_slot} < lanes_used) &&
                 !failed_mask[slot_idx] && !reported_mask[slot_idx];

  lmsc_check u_check (
    .status_word     (status_word),
    .idle_ack        (idle_ack),
    .receiver_number (receiver_number),
    .err_ceiling     (err_ceiling),
    .direction       (direction),
    .chk             (chk)
  );

  // A failing lane records the last step that passed.
  assign wr_rec.steps   = step_num - STEP_W'(1);
  assign wr_rec.verdict = chk.verdict;
  assign mem_wr = in_fire && (op == lmsc_pkg::OP_READBACK) && rb_ok && !chk.pass;

  assign fin_last = ((CNT_W'(fin_idx) + CNT_W'(1)) == lanes_used);

  // The next record is fetched while the current one is handed out.
  assign mem_rd = (state == S_FIN_RD) || ((state == S_FIN_EMIT) && out_free && !fin_last);
  assign mem_rd_addr = (state == S_FIN_RD) ? fin_idx : fin_idx + LANE_W'(1);

  lmsc_rec_mem #(
    .DEPTH  (SLOT_COUNT),
    .ADDR_W (LANE_W)
  ) u_rec_mem (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (slot_idx),
    .wr_data (wr_rec),
    .rd_en   (mem_rd),
    .rd_addr (mem_rd_addr),
    .rd_data (rd_rec)
  );

  // Lanes that never failed passed every step of the sweep.
  always_comb begin
    if (failed_mask[fin_idx]) begin
      fin_rec = rd_rec;
    end else begin
      fin_rec.steps   = start_steps;
      fin_rec.verdict = lmsc_pkg::VERDICT_THRESHOLD;
    end
  end

  // Step command: payload in the high byte, type and receiver below. The
  // step value is cut to the width of the payload's step field.
  always_comb begin
    case (direction)
      lmsc_pkg::DIR_TIMING_LEFT: begin
        cmd_payload = {2'b01, step_num[5:0]};
        cmd_type    = lmsc_pkg::MTYPE_TIMING;
      end
      lmsc_pkg::DIR_TIMING_RIGHT: begin
        cmd_payload = {2'b00, step_num[5:0]};
        cmd_type    = lmsc_pkg::MTYPE_TIMING;
      end
      lmsc_pkg::DIR_VOLTAGE_DOWN: begin
        cmd_payload = {1'b1, step_num};
        cmd_type    = lmsc_pkg::MTYPE_VOLTAGE;
      end
      default: begin
        cmd_payload = {1'b0, step_num};
        cmd_type    = lmsc_pkg::MTYPE_VOLTAGE;
      end
    endcase
    cmd_word = {cmd_payload, 2'b00, cmd_type, receiver_number};
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      receiver_number <= 3'd1;
      err_ceiling     <= 6'd4;
      direction       <= lmsc_pkg::DIR_TIMING_LEFT;
      total_steps     <= '0;
      lane_count      <= CNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lmsc_pkg::REG_RECEIVER:    receiver_number <= cfg_data[2:0];
        lmsc_pkg::REG_ERR_CEILING: err_ceiling     <= cfg_data[5:0];
        lmsc_pkg::REG_DIRECTION:   direction       <= cfg_data[1:0];
        lmsc_pkg::REG_TOTAL_STEPS: total_steps     <= cfg_data[STEP_W-1:0];
        lmsc_pkg::REG_LANE_COUNT:  lane_count      <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, sweep state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      sweep_active  <= 1'b0;
      step_num      <= '0;
      failed_mask   <= '0;
      reported_mask <= '0;
      fin_idx       <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (op == lmsc_pkg::OP_START) begin
              failed_mask   <= '0;
              reported_mask <= '0;
              step_num      <= '0;
              sweep_active  <= 1'b1;
              start_steps   <= total_steps;
              state         <= S_ADV;
            end else if (rb_ok) begin
              reported_mask[slot_idx] <= 1'b1;
              if (!chk.pass) begin
                failed_mask[slot_idx] <= 1'b1;
                fail_slot <= lane_slot;
                fail_rec  <= wr_rec;
                state     <= S_FAIL;
              end else begin
                state <= S_CHK;
              end
            end
          end
        end
        S_FAIL: begin
          if (out_free) begin
            kind         <= lmsc_pkg::KIND_FAILED;
            command_word <= '0;
            slot         <= fail_slot;
            lane_steps   <= fail_rec.steps;
            lane_verdict <= fail_rec.verdict;
            last         <= 1'b0;
            state        <= S_CHK;
          end
        end
        S_CHK: begin
          // The round closes once every slot in range failed or reported.
          if (((reported_mask | failed_mask) & lane_mask) == lane_mask) begin
            state <= S_ADV;
          end else begin
            state <= S_IDLE;
          end
        end
        S_ADV: begin
          if ((alive != '0) && (step_num < total_steps)) begin
            step_num      <= step_num + STEP_W'(1);
            reported_mask <= '0;
            state         <= S_CMD;
          end else begin
            sweep_active <= 1'b0;
            fin_idx      <= '0;
            state        <= (lanes_used == '0) ? S_IDLE : S_FIN_RD;
          end
        end
        S_CMD: begin
          if (out_free) begin
            kind         <= lmsc_pkg::KIND_STEP_CMD;
            command_word <= cmd_word;
            slot         <= '0;
            lane_steps   <= '0;
            lane_verdict <= '0;
            last         <= 1'b0;
            state        <= S_IDLE;
          end
        end
        S_FIN_RD: begin
          state <= S_FIN_EMIT;
        end
        S_FIN_EMIT: begin
          if (out_free) begin
            kind         <= lmsc_pkg::KIND_FINAL;
            command_word <= '0;
            slot         <= 5'(fin_idx);
            lane_steps   <= fin_rec.steps;
            lane_verdict <= fin_rec.verdict;
            last         <= fin_last;
            if (fin_last) begin
              state <= S_IDLE;
            end else begin
              fin_idx <= fin_idx + LANE_W'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== tb/lane_margin_sweep_controller_core_tb.sv =====
// ----------------------------------------------------------------------------
// Lane margin sweep controller core testbench
// Drives start and readback words into the sweep controller and configures it
// between phases. A predictor of the sweep state, updated per accepted word,
// computes each step command, lane failure and final lane record. A checker
// compares every result word, field by field, against the oldest expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module lane_margin_sweep_controller_core_tb;

  localparam int LANE_SLOTS     = lmsc_pkg::SLOT_COUNT_DEF;
  localparam int MAX_GAP        = 30;   // longest sender gap in cycles
  localparam int SETTLE_CYCLES  = 8;    // covers a readback that yields no word
  localparam int DRAIN_CYCLES   = 40;   // covers a full close of 32 lane records
  localparam int WATCHDOG_LIMIT = 2000;

  // One result word as it leaves the block.
  typedef struct packed {
    logic [lmsc_pkg::KIND_W-1:0] kind;
    logic [15:0]                 command_word;
    logic [4:0]                  slot;
    logic [lmsc_pkg::STEP_W-1:0] steps;
    logic [lmsc_pkg::VERD_W-1:0] verdict;
    logic                        last;
  } sweep_word_t;

  // Ways a readback can be spoiled so that the lane fails.
  typedef enum int {
    FAULT_STATUS, FAULT_ERRORS, FAULT_TYPE, FAULT_RECEIVER, FAULT_NO_ACK, FAULT_GARBAGE
  } fault_t;

  // --------------------------------------------------------------------------
  // Clock, reset and the signals of the block.
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #2 clk = ~clk;

  logic                            cfg_valid    = 1'b0;
  logic                            cfg_ready;
  logic [lmsc_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [lmsc_pkg::CFG_DATA_W-1:0] cfg_data     = '0;
  logic                            in_valid     = 1'b0;
  logic                            in_ready;
  logic                            op           = lmsc_pkg::OP_START;
  logic [4:0]                      lane_slot    = '0;
  logic [15:0]                     status_word  = '0;
  logic                            idle_ack     = 1'b0;
  logic                            out_valid;
  logic                            out_ready    = 1'b0;
  logic [lmsc_pkg::KIND_W-1:0]     kind;
  logic [15:0]                     command_word;
  logic [4:0]                      slot;
  logic [lmsc_pkg::STEP_W-1:0]     lane_steps;
  logic [lmsc_pkg::VERD_W-1:0]     lane_verdict;
  logic                            last;

  lane_margin_sweep_controller_core dut (.*);

  // --------------------------------------------------------------------------
  // Predictor state. The register copies start at their reset values, and
  // the sweep state starts idle with every mask clear.
  // --------------------------------------------------------------------------
  logic [2:0]                  cfg_receiver  = 3'd1;
  logic [5:0]                  cfg_err_limit = 6'd4;
  logic [1:0]                  cfg_direction = lmsc_pkg::DIR_TIMING_LEFT;
  logic [lmsc_pkg::STEP_W-1:0] cfg_total     = '0;
  logic [lmsc_pkg::CNT_W-1:0]  cfg_lanes     = 6'd1;

  logic [lmsc_pkg::STEP_W-1:0] sweep_step     = '0;
  logic                        sweep_running  = 1'b0;
  logic [31:0]                 lanes_failed   = '0;
  logic [31:0]                 lanes_reported = '0;
  logic [lmsc_pkg::STEP_W-1:0] rec_steps   [LANE_SLOTS];
  logic [lmsc_pkg::VERD_W-1:0] rec_verdict [LANE_SLOTS];

  sweep_word_t results_due[$];

  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned useful_words    = 0;
  int unsigned mismatch_count  = 0;
  int unsigned quiet_cycles    = 0;

  // Lane counts above the slot total behave as the slot total.
  function automatic int unsigned lanes_in_use();
    return (cfg_lanes > LANE_SLOTS) ? LANE_SLOTS : cfg_lanes;
  endfunction

  function automatic logic [31:0] slot_mask();
    logic [32:0] m;
    m = (33'd1 << lanes_in_use()) - 33'd1;
    return m[31:0];
  endfunction

  function automatic bit is_timing();
    return cfg_direction == lmsc_pkg::DIR_TIMING_LEFT ||
           cfg_direction == lmsc_pkg::DIR_TIMING_RIGHT;
  endfunction

  function automatic logic [2:0] margin_type();
    return is_timing() ? lmsc_pkg::MTYPE_TIMING : lmsc_pkg::MTYPE_VOLTAGE;
  endfunction

  // Timing steps carry a 6-bit step under the left bit, voltage steps a
  // 7-bit step under the down bit; wider steps are simply truncated.
  function automatic logic [15:0] step_command();
    logic [7:0] payload;
    if (is_timing()) begin
      payload = {1'b0, cfg_direction == lmsc_pkg::DIR_TIMING_LEFT, sweep_step[5:0]};
    end else begin
      payload = {cfg_direction == lmsc_pkg::DIR_VOLTAGE_DOWN, sweep_step[6:0]};
    end
    return {payload, 2'b00, margin_type(), cfg_receiver};
  endfunction

  function automatic void push_result(logic [lmsc_pkg::KIND_W-1:0] k, logic [15:0] cmd,
                                      logic [4:0] s, logic [lmsc_pkg::STEP_W-1:0] st,
                                      logic [lmsc_pkg::VERD_W-1:0] v, logic l);
    sweep_word_t w;
    w.kind         = k;
    w.command_word = cmd;
    w.slot         = s;
    w.steps        = st;
    w.verdict      = v;
    w.last         = l;
    results_due.push_back(w);
  endfunction

  // Either issue the next step command or close the sweep with one record
  // per lane slot, the last one marked.
  function automatic void next_step_or_close();
    logic [31:0] alive;
    int unsigned n;
    alive = slot_mask() & ~lanes_failed;
    if (alive != 0 && sweep_step < cfg_total) begin
      sweep_step     = sweep_step + 1'b1;
      lanes_reported = '0;
      push_result(lmsc_pkg::KIND_STEP_CMD, step_command(), '0, '0,
                  lmsc_pkg::VERDICT_THRESHOLD, 1'b0);
    end else begin
      sweep_running = 1'b0;
      n = lanes_in_use();
      for (int i = 0; i < n; i++) begin
        push_result(lmsc_pkg::KIND_FINAL, '0, 5'(i), rec_steps[i], rec_verdict[i],
                    i == n - 1);
      end
    end
  endfunction

  // Updates the sweep state for one accepted word and queues the words it
  // causes. Returns 1 when the block ignores the word.
  function automatic bit predict_word(logic o, logic [4:0] s, logic [15:0] sw, logic a);
    logic [31:0] lane_bit;
    logic [1:0]  sts;
    logic        pass;
    if (o == lmsc_pkg::OP_START) begin
      for (int i = 0; i < LANE_SLOTS; i++) begin
        rec_steps[i]   = cfg_total;
        rec_verdict[i] = lmsc_pkg::VERDICT_THRESHOLD;
      end
      lanes_failed   = '0;
      lanes_reported = '0;
      sweep_step     = '0;
      sweep_running  = 1'b1;
      next_step_or_close();
      return 1'b0;
    end
    if (!sweep_running || s >= lanes_in_use()) return 1'b1;
    lane_bit = 32'd1 << s;
    if (((lanes_failed | lanes_reported) & lane_bit) != 0) return 1'b1;
    lanes_reported |= lane_bit;
    sts  = sw[15:14];
    pass = sw[5:3] == margin_type() && sw[2:0] == cfg_receiver &&
           sts == lmsc_pkg::MSTS_MARGINING && sw[13:8] <= cfg_err_limit && a;
    if (!pass) begin
      lanes_failed |= lane_bit;
      rec_steps[s]  = sweep_step - 1'b1;
      // Odd margin status codes are the two refusal codes.
      rec_verdict[s] = sts[0] ? lmsc_pkg::VERDICT_NAK : lmsc_pkg::VERDICT_LIMIT;
      push_result(lmsc_pkg::KIND_FAILED, '0, s, rec_steps[s], rec_verdict[s], 1'b0);
    end
    if (((lanes_reported | lanes_failed) & slot_mask()) == slot_mask()) next_step_or_close();
    return 1'b0;
  endfunction

  function automatic void apply_reg(logic [lmsc_pkg::CFG_IDX_W-1:0] idx,
                                    logic [lmsc_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      lmsc_pkg::REG_RECEIVER:    cfg_receiver  = data[2:0];
      lmsc_pkg::REG_ERR_CEILING: cfg_err_limit = data[5:0];
      lmsc_pkg::REG_DIRECTION:   cfg_direction = data[1:0];
      lmsc_pkg::REG_TOTAL_STEPS: cfg_total     = data[lmsc_pkg::STEP_W-1:0];
      lmsc_pkg::REG_LANE_COUNT:  cfg_lanes     = data[lmsc_pkg::CNT_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [15:0] make_status(logic [1:0] sts, logic [5:0] errs,
                                              logic [2:0] mtype, logic [2:0] rcv);
    return {sts, errs, 2'b00, mtype, rcv};
  endfunction

  // --------------------------------------------------------------------------
  // Drivers. All inputs change with nonblocking assignments right after a
  // rising edge, and handshakes are sampled right after the edge, so both
  // sides see the values that were present at the edge itself.
  // --------------------------------------------------------------------------

  // Sends one word. The valid is left high on return so that a word that
  // follows at once keeps it high; settle() or a gap lowers it.
  task automatic send_word(input logic o, input logic [4:0] s, input logic [15:0] sw,
                           input logic a);
    int unsigned gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= o;
    lane_slot   <= s;
    status_word <= sw;
    idle_ack    <= a;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!predict_word(o, s, sw, a)) useful_words++;
  endtask

  // Writes one register. With hold set the valid stays high for a write that
  // follows at once.
  task automatic write_reg(input logic [lmsc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lmsc_pkg::CFG_DATA_W-1:0] data, input bit hold);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, data);
    if (!hold) cfg_valid <= 1'b0;
  endtask

  task automatic program_sweep(input logic [7:0] rcv, input logic [7:0] elim,
                               input logic [7:0] dir, input logic [7:0] total,
                               input logic [7:0] lanes);
    write_reg(lmsc_pkg::REG_RECEIVER, rcv, 1'b1);
    write_reg(lmsc_pkg::REG_ERR_CEILING, elim, 1'b1);
    write_reg(lmsc_pkg::REG_DIRECTION, dir, 1'b1);
    write_reg(lmsc_pkg::REG_TOTAL_STEPS, total, 1'b1);
    write_reg(lmsc_pkg::REG_LANE_COUNT, lanes, 1'b0);
  endtask

  // Stops sending, waits for every expected word, then gives the block a few
  // cycles to finish a readback that produces nothing.
  task automatic settle();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random readback content. A pass_pct share of words pass; the rest are
  // spoiled in one specific way or are plain noise.
  task automatic pick_status(input int unsigned pass_pct, output logic [15:0] sw,
                             output logic a);
    fault_t fault;
    sw = {lmsc_pkg::MSTS_MARGINING, 6'($urandom_range(cfg_err_limit, 0)), 2'($urandom),
          margin_type(), cfg_receiver};
    a  = 1'b1;
    if ($urandom_range(99) >= pass_pct) begin
      fault = fault_t'($urandom_range(FAULT_GARBAGE));
      case (fault)
        FAULT_STATUS:   sw[15:14] = sw[15:14] ^ 2'($urandom_range(3, 1));
        FAULT_ERRORS: begin
          if (cfg_err_limit != 6'h3F) sw[13:8] = 6'($urandom_range(63, cfg_err_limit + 1));
          else a = 1'b0;
        end
        FAULT_TYPE:     sw[5:3] = sw[5:3] ^ 3'($urandom_range(7, 1));
        FAULT_RECEIVER: sw[2:0] = sw[2:0] ^ 3'($urandom_range(7, 1));
        FAULT_NO_ACK:   a = 1'b0;
        default: begin
          sw = 16'($urandom);
          a  = 1'($urandom);
        end
      endcase
    end
  endtask

  // Random register set for one sweep. Most sweeps are short; a few use the
  // full slot count or a long step total on a single lane. Upper data bits
  // are random since the block keeps only the register width.
  task automatic program_random_sweep();
    logic [5:0] lanes;
    logic [6:0] total;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 6) lanes = 6'd0;
    else if (r < 16) lanes = 6'($urandom_range(63, 32));
    else lanes = 6'($urandom_range(6, 1));
    r = $urandom_range(99);
    if (r < 8) total = 7'd0;
    else if (lanes >= LANE_SLOTS) total = 7'($urandom_range(2, 1));
    else if (r < 16 && lanes == 1) total = 7'($urandom_range(127, 20));
    else total = 7'($urandom_range(6, 1));
    program_sweep(8'($urandom), 8'($urandom), 8'($urandom), {1'($urandom), total},
                  {2'($urandom), lanes});
  endtask

  // --------------------------------------------------------------------------
  // Checker and handshake helpers on the output side.
  // --------------------------------------------------------------------------
  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    sweep_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected word kind %0h slot %0h expected none actual %0h",
                 $time, kind, slot, command_word);
        mismatch_count++;
      end else begin
        want = results_due.pop_front();
        check_field("kind", want.kind, kind);
        check_field("command_word", want.command_word, command_word);
        check_field("slot", want.slot, slot);
        check_field("lane_steps", want.steps, lane_steps);
        check_field("lane_verdict", want.verdict, lane_verdict);
        check_field("last", want.last, last);
      end
    end
  end

  // The watchdog trips when no channel moves a word for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d words outstanding", $time, results_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Reset values: one lane, no steps. A readback before any start is ignored,
  // and a start closes the sweep at once with a single marked record.
  task automatic test_reset_values();
    send_word(lmsc_pkg::OP_READBACK, 5'd0,
              make_status(lmsc_pkg::MSTS_MARGINING, 6'd0, lmsc_pkg::MTYPE_TIMING, 3'd1),
              1'b1);
    send_word(lmsc_pkg::OP_START, 5'd31, 16'hFFFF, 1'b1);
    settle();
  endtask

  // Zero lanes: a start produces nothing and the sweep is over, so a later
  // readback is ignored too. The step total is zeroed with a stray top bit.
  task automatic test_no_lanes();
    write_reg(lmsc_pkg::REG_TOTAL_STEPS, 8'h80, 1'b1);
    write_reg(lmsc_pkg::REG_LANE_COUNT, 8'h40, 1'b0);
    send_word(lmsc_pkg::OP_START, 5'd0, 16'h0000, 1'b0);
    send_word(lmsc_pkg::OP_READBACK, 5'd0, 16'h0000, 1'b0);
    settle();
  endtask

  // A timing-right sweep over three lanes: a pass, a missing idle
  // acknowledge, a repeated readback, an out-of-range slot, then a refusal
  // and an error count one above a zero limit finish every lane.
  task automatic test_timing_round();
    logic [15:0] good;
    program_sweep(8'd7, 8'd0, lmsc_pkg::DIR_TIMING_RIGHT, 8'd2, 8'd3);
    good = make_status(lmsc_pkg::MSTS_MARGINING, 6'd0, lmsc_pkg::MTYPE_TIMING, 3'd7);
    send_word(lmsc_pkg::OP_START, 5'd0, 16'h0000, 1'b0);
    send_word(lmsc_pkg::OP_READBACK, 5'd0, good, 1'b1);
    send_word(lmsc_pkg::OP_READBACK, 5'd1, good, 1'b0);
    send_word(lmsc_pkg::OP_READBACK, 5'd0, good, 1'b1);
    send_word(lmsc_pkg::OP_READBACK, 5'd31, good, 1'b1);
    send_word(lmsc_pkg::OP_READBACK, 5'd2, good, 1'b1);
    send_word(lmsc_pkg::OP_READBACK, 5'd1, good, 1'b1);
    send_word(lmsc_pkg::OP_READBACK, 5'd0,
              make_status(2'b11, 6'd0, lmsc_pkg::MTYPE_TIMING, 3'd7), 1'b1);
    send_word(lmsc_pkg::OP_READBACK, 5'd2,
              make_status(lmsc_pkg::MSTS_MARGINING, 6'd1, lmsc_pkg::MTYPE_TIMING, 3'd7),
              1'b1);
    settle();
  endtask

  // Voltage-down sweep, all registers at their top value but the zero receiver
  // and the lane count above the slot total. It is cut to one in mid-sweep,
  // then a start restarts the sweep and an all-ones status refuses the lane.
  task automatic test_restart_and_live_config();
    program_sweep(8'hF8, 8'hFF, 8'hFF, 8'hFF, 8'hE8);
    send_word(lmsc_pkg::OP_START, 5'd31, 16'hFFFF, 1'b1);
    settle();
    write_reg(lmsc_pkg::REG_LANE_COUNT, 8'd1, 1'b0);
    send_word(lmsc_pkg::OP_READBACK, 5'd0,
              make_status(lmsc_pkg::MSTS_MARGINING, 6'h3F, lmsc_pkg::MTYPE_VOLTAGE, 3'd0),
              1'b1);
    send_word(lmsc_pkg::OP_START, 5'd0, 16'h0000, 1'b0);
    send_word(lmsc_pkg::OP_READBACK, 5'd0, 16'hFFFF, 1'b1);
    settle();
  endtask

  // Voltage-up sweep of one step where both lanes pass, reported out of order.
  task automatic test_voltage_up();
    program_sweep(8'd3, 8'd4, lmsc_pkg::DIR_VOLTAGE_UP, 8'd1, 8'd2);
    send_word(lmsc_pkg::OP_START, 5'd0, 16'h0000, 1'b0);
    send_word(lmsc_pkg::OP_READBACK, 5'd1,
              make_status(lmsc_pkg::MSTS_MARGINING, 6'd4, lmsc_pkg::MTYPE_VOLTAGE, 3'd3),
              1'b1);
    send_word(lmsc_pkg::OP_READBACK, 5'd0,
              make_status(lmsc_pkg::MSTS_MARGINING, 6'd0, lmsc_pkg::MTYPE_VOLTAGE, 3'd3),
              1'b1);
    settle();
  endtask

  // One lane swept through all 127 timing steps: the step wraps inside its
  // 6-bit field past 63 and the lane ends at the threshold with 127 steps.
  task automatic test_long_sweep();
    logic [15:0] sw;
    logic        a;
    program_sweep(8'd5, 8'd10, lmsc_pkg::DIR_TIMING_LEFT, 8'd127, 8'd1);
    send_word(lmsc_pkg::OP_START, 5'd0, 16'h0000, 1'b0);
    while (sweep_running) begin
      pick_status(100, sw, a);
      send_word(lmsc_pkg::OP_READBACK, 5'd0, sw, a);
    end
    settle();
  endtask

  // Random sweeps under one idling pattern. Readbacks mostly go to lanes
  // still waiting in the current step; some are noise to arbitrary slots,
  // and now and then a start cuts a sweep short.
  task automatic test_random_sweeps(input int unsigned send_idle, input int unsigned stall,
                                    input int unsigned budget);
    int unsigned stop_at;
    int unsigned r;
    logic [4:0]  waiting[$];
    logic [15:0] sw;
    logic        a;
    sender_idle_pct = send_idle;
    recv_stall_pct  = stall;
    stop_at = useful_words + budget;
    while (useful_words < stop_at) begin
      settle();
      if ($urandom_range(99) < 75) program_random_sweep();
      send_word(lmsc_pkg::OP_START, 5'($urandom), 16'($urandom), 1'($urandom));
      while (sweep_running && useful_words < stop_at) begin
        waiting.delete();
        for (int i = 0; i < lanes_in_use(); i++) begin
          if (!lanes_failed[i] && !lanes_reported[i]) waiting.push_back(5'(i));
        end
        r = $urandom_range(99);
        if (r < 3) begin
          send_word(lmsc_pkg::OP_START, 5'($urandom), 16'($urandom), 1'($urandom));
        end else if (r < 12 || waiting.size() == 0) begin
          pick_status(50, sw, a);
          send_word(lmsc_pkg::OP_READBACK, 5'($urandom), sw, a);
        end else begin
          pick_status(78, sw, a);
          send_word(lmsc_pkg::OP_READBACK, waiting[$urandom_range(waiting.size() - 1)],
                    sw, a);
        end
      end
      if ($urandom_range(99) < 15) begin
        pick_status(50, sw, a);
        send_word(lmsc_pkg::OP_READBACK, 5'($urandom), sw, a);
      end
    end
    settle();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence: reset once, directed tests without idling, then the long
  // sweep and random sweeps under each idling pattern.
  // --------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_no_lanes();
    test_timing_round();
    test_restart_and_live_config();
    test_voltage_up();
    test_long_sweep();
    test_random_sweeps(0, 0, 60);
    test_random_sweeps(68, 0, 60);
    test_random_sweeps(0, 68, 60);
    test_random_sweeps(20, 20, 60);
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
